// ===== src/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the polyline segment extrusion block.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int COORD_BITS = 24;
    localparam int WIDTH_BITS = 16;
    // the larger normalised magnitude lies in [2^29, 2^30)
    localparam int NORM_BITS  = 30;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * NORM_BITS + 1;
    localparam int ROOT_BITS  = NORM_BITS + 1;
    localparam int NUM_BITS   = NORM_BITS + WIDTH_BITS;
    localparam int Q_BITS     = WIDTH_BITS;
    localparam int MUL_DIGIT  = 2;
    localparam int CNT_BITS   = 6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [WIDTH_BITS-1:0]        stroke_width;
        logic                         new_line;
    } pse_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } pse_out_t;

endpackage

// ===== src/pse_serial_mul.sv =====
// ----------------------------------------------------------------------------
// pse_serial_mul
// Unsigned shift-and-add multiplier, one multiplier digit per cycle.
// ----------------------------------------------------------------------------
module pse_serial_mul
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pse_pkg::NORM_BITS-1:0]    a,
    input  logic [pse_pkg::NORM_BITS-1:0]    b,
    output logic                             busy,
    output logic [2*pse_pkg::NORM_BITS-1:0]  product
);
    import pse_pkg::*;

    localparam int STEPS = NORM_BITS / MUL_DIGIT;

    logic [2*NORM_BITS-1:0] acc_reg, acc_next;
    logic [2*NORM_BITS-1:0] mcand_reg, mcand_next;
    logic [NORM_BITS-1:0]   mplier_reg, mplier_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [2*NORM_BITS-1:0] part;

    always_comb
    begin
        part = mcand_reg * (2*NORM_BITS)'(mplier_reg[MUL_DIGIT-1:0]);
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = {{NORM_BITS{1'b0}}, a};
            mplier_next = b;
            cnt_next    = CNT_BITS'(STEPS);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = acc_reg + part;
            mcand_next  = mcand_reg << MUL_DIGIT;
            mplier_next = mplier_reg >> MUL_DIGIT;
            cnt_next    = cnt_reg - 1'b1;
            busy_next   = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ===== src/pse_isqrt.sv =====
// ----------------------------------------------------------------------------
// pse_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pse_isqrt
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pse_pkg::SQ_BITS-1:0]     radicand,
    output logic                            busy,
    output logic [pse_pkg::ROOT_BITS-1:0]   root
);
    import pse_pkg::*;

    logic [SQ_BITS+1:0]   rem_reg, rem_next;
    logic [SQ_BITS+1:0]   src_reg, src_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [SQ_BITS+1:0]   trial, shifted;

    always_comb
    begin
        shifted   = {rem_reg[SQ_BITS-1:0], src_reg[SQ_BITS+1:SQ_BITS]};
        trial     = shifted - {{(SQ_BITS-ROOT_BITS){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        src_next  = src_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            src_next  = {1'b0, radicand, 1'b0};
            root_next = '0;
            cnt_next  = CNT_BITS'(ROOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            src_next = src_reg << 2;
            if (!trial[SQ_BITS+1])
            begin
                rem_next  = trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        src_reg  <= src_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== src/pse_divider.sv =====
// ----------------------------------------------------------------------------
// pse_divider
// Restoring divider for the rounded normal, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pse_pkg::NUM_BITS:0]      dividend,
    input  logic [pse_pkg::ROOT_BITS:0]     divisor,
    output logic                            busy,
    output logic [pse_pkg::Q_BITS-1:0]      quotient
);
    import pse_pkg::*;

    // quotient < 2^Q_BITS, so only the low quotient bits are developed
    localparam int REM_BITS = ROOT_BITS + 2;

    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_BITS:0]    num_reg, num_next;
    logic [ROOT_BITS:0]   den_reg, den_next;
    logic [Q_BITS-1:0]    q_reg, q_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [REM_BITS-1:0]  shifted, trial;

    always_comb
    begin
        shifted   = {rem_reg[REM_BITS-2:0], num_reg[NUM_BITS]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = REM_BITS'(dividend >> Q_BITS);
            num_next  = dividend << (NUM_BITS + 1 - Q_BITS);
            den_next  = divisor;
            q_next    = '0;
            cnt_next  = CNT_BITS'(Q_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (!trial[REM_BITS-1])
            begin
                rem_next = trial;
                q_next   = {q_reg[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[Q_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== src/polyline_segment_extrusion.sv =====
// ----------------------------------------------------------------------------
// polyline_segment_extrusion
// Extrudes polyline segments into two triangles of six vertices.
// ----------------------------------------------------------------------------
// One point is taken per transaction and one point is in flight at a time.
// A point that ends a drawable segment holds the input off while the block
// steps through normalisation (one shift per cycle), two serial multiply
// passes for dx^2 and dy^2, a bit-serial square root that overlaps the
// |dy|*w product, two serial divisions (the second product overlaps the
// first), two register states, an emit and a wait state for each of the
// six vertex transactions and a return to idle. Output stalls lengthen the
// hold. A point that emits nothing does not hold the input off.
module polyline_segment_extrusion
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pse_pkg::pse_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pse_pkg::pse_out_t out_data
);
    import pse_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NORM  = 4'd1;
    localparam logic [3:0] ST_MULX  = 4'd2;
    localparam logic [3:0] ST_MULY  = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_MULWY = 4'd5;
    localparam logic [3:0] ST_DIVX  = 4'd6;
    localparam logic [3:0] ST_MULWX = 4'd7;
    localparam logic [3:0] ST_DIVY  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_WAIT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    // start point of the segment being extruded
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic prev_valid_reg;
    logic [WIDTH_BITS-1:0] w_reg;
    logic dx_neg_reg, dy_pos_reg;
    logic [NORM_BITS-1:0] mx_reg, my_reg;
    logic [SQ_BITS-1:0] sum_reg;
    logic [ROOT_BITS-1:0] len_reg;
    logic [Q_BITS-1:0] qx_reg, qy_reg;
    logic [2:0] vtx_reg;
    logic phase_reg;
    pse_out_t out_reg;
    logic out_valid_reg;

    logic mul_start, mul_busy, mul_done;
    logic sqrt_start, sqrt_busy, sqrt_done;
    logic div_start, div_busy, div_done;
    logic [NORM_BITS-1:0] mul_a, mul_b;
    logic [2*NORM_BITS-1:0] mul_p;
    logic [ROOT_BITS-1:0] root;
    logic [Q_BITS-1:0] quo;
    logic [NUM_BITS:0] div_num;

    logic accept, drawable;
    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [DIFF_BITS-1:0] adx, ady;
    logic signed [COORD_BITS+1:0] sx, sy, nxs, nys;
    logic signed [COORD_BITS-1:0] bx, by;
    logic sub;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        dx  = DIFF_BITS'(in_data.point_x) - DIFF_BITS'(px_reg);
        dy  = DIFF_BITS'(in_data.point_y) - DIFF_BITS'(py_reg);
        adx = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        ady = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        drawable = prev_valid_reg && !in_data.new_line && (in_data.stroke_width != '0)
                 && (dx != '0 || dy != '0);
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = mx_reg;
        mul_b = mx_reg;
        case (state_reg)
            ST_MULY:  begin mul_a = my_reg; mul_b = my_reg; end
            ST_SQRT:  begin mul_a = my_reg; mul_b = NORM_BITS'(w_reg); end
            ST_DIVX:  begin mul_a = mx_reg; mul_b = NORM_BITS'(w_reg); end
            default:  begin mul_a = mx_reg; mul_b = mx_reg; end
        endcase
    end

    assign div_num = (NUM_BITS+1)'(mul_p) + (NUM_BITS+1)'(len_reg);

    pse_serial_mul u_mul
    (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .busy(mul_busy), .product(mul_p)
    );

    pse_isqrt u_sqrt
    (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .radicand(sum_reg), .busy(sqrt_busy), .root(root)
    );

    pse_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_num), .divisor({len_reg, 1'b0}),
        .busy(div_busy), .quotient(quo)
    );

    // phase_reg is low in the first cycle of a state, when its unit is started
    assign mul_done  = phase_reg && !mul_busy;
    assign sqrt_done = phase_reg && !sqrt_busy;
    assign div_done  = phase_reg && !div_busy;

    always_comb
    begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && drawable)
                    state_next = ST_NORM;
            ST_NORM:
                if (mx_reg[NORM_BITS-1] || my_reg[NORM_BITS-1])
                    state_next = ST_MULX;
            ST_MULX:
            begin
                mul_start = !phase_reg;
                if (mul_done) state_next = ST_MULY;
            end
            ST_MULY:
            begin
                mul_start = !phase_reg;
                if (mul_done) state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sqrt_start = !phase_reg;
                mul_start  = !phase_reg;
                if (sqrt_done) state_next = ST_MULWY;
            end
            ST_MULWY:
                state_next = ST_DIVX;
            ST_DIVX:
            begin
                div_start = !phase_reg;
                mul_start = !phase_reg;
                if (div_done && !mul_busy) state_next = ST_MULWX;
            end
            ST_MULWX:
                state_next = ST_DIVY;
            ST_DIVY:
            begin
                div_start = !phase_reg;
                if (div_done) state_next = ST_EMIT;
            end
            ST_EMIT:
                state_next = ST_WAIT;
            ST_WAIT:
                if (!out_valid_reg || !out_stall)
                    state_next = (vtx_reg == 3'd6) ? ST_IDLE : ST_EMIT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // vertex selection: a, b, c, b, d, c
    always_comb
    begin
        bx  = (vtx_reg == 3'd2 || vtx_reg == 3'd4 || vtx_reg == 3'd5) ? px_reg : ox_reg;
        by  = (vtx_reg == 3'd2 || vtx_reg == 3'd4 || vtx_reg == 3'd5) ? py_reg : oy_reg;
        sub = (vtx_reg == 3'd1 || vtx_reg == 3'd3 || vtx_reg == 3'd4);
        nxs = dy_pos_reg ? -(COORD_BITS+2)'(qx_reg) : (COORD_BITS+2)'(qx_reg);
        nys = dx_neg_reg ? -(COORD_BITS+2)'(qy_reg) : (COORD_BITS+2)'(qy_reg);
        sx  = sub ? (COORD_BITS+2)'(bx) - nxs : (COORD_BITS+2)'(bx) + nxs;
        sy  = sub ? (COORD_BITS+2)'(by) - nys : (COORD_BITS+2)'(by) + nys;
    end

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [COORD_BITS+1:0] v);
        logic signed [COORD_BITS+1:0] hi, lo;
        hi = (COORD_BITS+2)'((1 <<< (COORD_BITS-1)) - 1);
        lo = -(COORD_BITS+2)'(1 <<< (COORD_BITS-1));
        if (v > hi)      sat = hi[COORD_BITS-1:0];
        else if (v < lo) sat = lo[COORD_BITS-1:0];
        else             sat = v[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            px_reg         <= '0;
            py_reg         <= '0;
            out_valid_reg  <= 1'b0;
            vtx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= (state_next == state_reg) ? 1'b1 : 1'b0;
            if (state_reg == ST_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                prev_valid_reg <= 1'b1;
                px_reg <= in_data.point_x;
                py_reg <= in_data.point_y;
            end
            if (state_reg == ST_EMIT)
                vtx_reg <= vtx_reg + 1'b1;
            else if (state_reg == ST_WAIT && state_next == ST_IDLE)
                vtx_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ox_reg     <= px_reg;
            oy_reg     <= py_reg;
            w_reg      <= in_data.stroke_width;
            dx_neg_reg <= dx[DIFF_BITS-1];
            dy_pos_reg <= !dy[DIFF_BITS-1] && (dy != '0);
            mx_reg     <= NORM_BITS'(adx);
            my_reg     <= NORM_BITS'(ady);
        end
        else if (state_reg == ST_NORM && !(mx_reg[NORM_BITS-1] || my_reg[NORM_BITS-1]))
        begin
            mx_reg <= mx_reg << 1;
            my_reg <= my_reg << 1;
        end
        // dx^2 is taken as the second square starts, dy^2 added when it ends
        if (state_reg == ST_MULY)
        begin
            if (!phase_reg)
                sum_reg <= SQ_BITS'(mul_p);
            else if (mul_done)
                sum_reg <= sum_reg + SQ_BITS'(mul_p);
        end
        if (state_reg == ST_MULWY)
            len_reg <= root;
        if (state_reg == ST_MULWX)
            qx_reg <= quo;
        if (state_reg == ST_DIVY && div_done)
            qy_reg <= quo;
        if (state_reg == ST_EMIT)
        begin
            out_reg.vertex_x    <= sat(sx);
            out_reg.vertex_y    <= sat(sy);
            out_reg.last_vertex <= (vtx_reg == 3'd5);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== bench/tb_polyline_segment_extrusion.sv =====
// ----------------------------------------------------------------------------
// tb_polyline_segment_extrusion
// Drives polyline points into the extrusion block and checks every emitted
// vertex against a fixed-point predictor of the segment normal and corners.
// ----------------------------------------------------------------------------
module tb_polyline_segment_extrusion;
    import pse_pkg::*;

    localparam int RANDOM_POINTS = 204;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        pse_in_t  pt;
        logic     has_exp;
        pse_out_t exp0;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pse_in_t in_data;
    logic out_valid;
    logic out_stall;
    pse_out_t out_data;

    polyline_segment_extrusion dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    pse_out_t vertex_queue[$];
    longint prev_px;
    longint prev_py;
    bit prev_ok;
    int mismatches;
    int vertices_seen;
    int points_sent;
    int idle_cycles;
    bit stimulus_done;
    bit hold_receiver;
    bit timed_out;
    stim_row_t rows[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clamp_coord(longint v);
        longint hi;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic pse_out_t make_vertex(longint x, longint y, logic last);
        pse_out_t v;
        v.vertex_x = COORD_BITS'(clamp_coord(x));
        v.vertex_y = COORD_BITS'(clamp_coord(y));
        v.last_vertex = last;
        return v;
    endfunction

    // updates the stored point and, for a drawable segment, queues its six corners
    task automatic extrude_point(input pse_in_t pt);
        longint x0, y0, x1, y1, dx, dy, nx, ny;
        longint unsigned mx, my, m, len, w, q;
        bit drawable;
        x1 = longint'(pt.point_x);
        y1 = longint'(pt.point_y);
        w = 64'(pt.stroke_width);
        x0 = prev_px;
        y0 = prev_py;
        drawable = prev_ok && !pt.new_line;
        prev_px = x1;
        prev_py = y1;
        prev_ok = 1'b1;
        dx = x1 - x0;
        dy = y1 - y0;
        if (!drawable || w == 0 || (dx == 0 && dy == 0))
            return;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        m = mx > my ? mx : my;
        while (m >= (64'd1 << 30))
        begin
            mx = mx >> 1; my = my >> 1; m = m >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            mx = mx << 1; my = my << 1; m = m << 1;
        end
        len = int_sqrt(mx * mx + my * my);
        q = (my * w + len) / (2 * len);
        nx = dy > 0 ? -longint'(q) : longint'(q);
        q = (mx * w + len) / (2 * len);
        ny = dx < 0 ? -longint'(q) : longint'(q);
        vertex_queue.push_back(make_vertex(x0 + nx, y0 + ny, 1'b0));
        vertex_queue.push_back(make_vertex(x0 - nx, y0 - ny, 1'b0));
        vertex_queue.push_back(make_vertex(x1 + nx, y1 + ny, 1'b0));
        vertex_queue.push_back(make_vertex(x0 - nx, y0 - ny, 1'b0));
        vertex_queue.push_back(make_vertex(x1 - nx, y1 - ny, 1'b0));
        vertex_queue.push_back(make_vertex(x1 + nx, y1 + ny, 1'b1));
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic pse_in_t mk_point(int x, int y, int w, logic nl);
        pse_in_t p;
        p.point_x = COORD_BITS'(x);
        p.point_y = COORD_BITS'(y);
        p.stroke_width = WIDTH_BITS'(w);
        p.new_line = nl;
        return p;
    endfunction

    function automatic stim_row_t mk_row(pse_in_t p, logic has, pse_out_t e);
        stim_row_t r;
        r.pt = p;
        r.has_exp = has;
        r.exp0 = e;
        return r;
    endfunction

    task automatic send_point(input pse_in_t pt);
        in_valid <= 1'b1;
        in_data <= pt;
        do
            @(posedge clk);
        while (in_stall);
        extrude_point(pt);
        points_sent++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (vertex_queue.size() != 0)
            @(posedge clk);
    endtask

    // random sender stimulus: mostly well-formed polylines, some noise
    task automatic random_points();
        pse_in_t p;
        int kind;
        int cx, cy, span;
        for (int i = 0; i < RANDOM_POINTS; i++)
        begin
            kind = $urandom_range(0, 9);
            p.new_line = ($urandom_range(0, 7) == 0);
            p.stroke_width = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
            if (kind < 6)
            begin
                // short step from the previous point
                span = 1 << $urandom_range(0, 20);
                cx = int'(prev_px) + $urandom_range(0, 2 * span) - span;
                cy = int'(prev_py) + $urandom_range(0, 2 * span) - span;
                p.point_x = COORD_BITS'(cx);
                p.point_y = COORD_BITS'(cy);
            end
            else if (kind < 9)
            begin
                p.point_x = COORD_BITS'($urandom);
                p.point_y = COORD_BITS'($urandom);
            end
            else
            begin
                p.point_x = COORD_BITS'(prev_px);
                p.point_y = COORD_BITS'(prev_py);
            end
            if (i == 110)
            begin
                // receiver held off while the sender keeps offering points
                hold_receiver = 1'b1;
            end
            if (i == 160)
                wait_drained();
            send_point(p);
            idle_sender(pick_gap());
        end
    endtask

    initial
    begin
        pse_out_t e;
        pse_out_t got;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        prev_px = 0;
        prev_py = 0;
        prev_ok = 1'b0;
        mismatches = 0;
        vertices_seen = 0;
        points_sent = 0;
        stimulus_done = 1'b0;
        hold_receiver = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        e = '0;
        // first point after reset, then a horizontal segment of width 2.0
        rows.push_back(mk_row(mk_point(0, 0, 512, 1'b0), 1'b0, e));
        e = make_vertex(0, 256, 1'b0);
        rows.push_back(mk_row(mk_point(2560, 0, 512, 1'b0), 1'b1, e));
        // vertical segment, normal along -x
        e = make_vertex(2560 - 256, 0, 1'b0);
        rows.push_back(mk_row(mk_point(2560, 2560, 512, 1'b0), 1'b1, e));
        // zero width, zero length, new line
        rows.push_back(mk_row(mk_point(0, 0, 0, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(0, 0, 65535, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(100, 100, 65535, 1'b1), 1'b0, e));
        // extremes of the coordinate range with saturation
        rows.push_back(mk_row(mk_point(-8388608, -8388608, 65535, 1'b1), 1'b0, e));
        rows.push_back(mk_row(mk_point(8388607, 8388607, 65535, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(-8388608, 8388607, 65535, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(8388607, -8388608, 1, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(8388606, -8388608, 1, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(-1, -1, 65535, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(0, 0, 32768, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(-3, 7, 255, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(5592405, -5592406, 43690, 1'b0), 1'b0, e));
        rows.push_back(mk_row(mk_point(-5592406, 5592405, 21845, 1'b0), 1'b0, e));

        foreach (rows[i])
        begin
            if (rows[i].has_exp)
            begin
                // typed-in first vertex checked with nothing else queued
                wait_drained();
                send_point(rows[i].pt);
                got = (vertex_queue.size() != 0) ? vertex_queue[0] : '0;
                if (vertex_queue.size() != 6 || got !== rows[i].exp0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: expected x=%0d y=%0d, got x=%0d y=%0d (%0d queued)",
                                 i, rows[i].exp0.vertex_x, rows[i].exp0.vertex_y,
                                 got.vertex_x, got.vertex_y, vertex_queue.size());
                end
            end
            else
                send_point(rows[i].pt);
            idle_sender(pick_gap());
        end
        wait_drained();

        random_points();
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver stalls, with one long hold-off
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_receiver = 1'b0;
                out_stall <= 1'b0;
            end
            else if (pick_gap() > 0)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    // vertex checker
    always @(posedge clk)
    begin
        pse_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            vertices_seen++;
            if (vertex_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d last=%0b",
                             out_data.vertex_x, out_data.vertex_y, out_data.last_vertex);
            end
            else
            begin
                want = vertex_queue.pop_front();
                if (out_data.vertex_x !== want.vertex_x || out_data.vertex_y !== want.vertex_y
                    || out_data.last_vertex !== want.last_vertex)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex: expected x=%0d y=%0d last=%0b, got %0d %0d %0b",
                                 want.vertex_x, want.vertex_y, want.last_vertex,
                                 out_data.vertex_x, out_data.vertex_y, out_data.last_vertex);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        wait (timed_out || (stimulus_done && vertex_queue.size() == 0));
        if (!timed_out)
            repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d points sent, %0d vertices checked, %0d mismatches",
                 points_sent, vertices_seen, mismatches);
        $display("covered: new lines, zero width, zero length, saturation, long stalls");
        if (!timed_out && mismatches == 0 && vertex_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== polyline_segment_extrusion.f =====
src/pse_pkg.sv
src/pse_serial_mul.sv
src/pse_isqrt.sv
src/pse_divider.sv
src/polyline_segment_extrusion.sv
bench/tb_polyline_segment_extrusion.sv
